>>> design/rog_pkg.sv
// Shared types, constants and the generator step function for the order generator.
`default_nettype none

package rog_pkg;

  localparam int DRAW_W     = 64;
  localparam int BAND_W     = 31;
  localparam int MOD_W      = BAND_W + 1;
  localparam int CENTER_W   = 47;
  localparam int PRICE_W    = 48;
  localparam int OFFSET_W   = MOD_W + 1;
  localparam int QTY_W      = 7;
  localparam int ID_OUT_W   = 32;
  localparam int ID_BITS_DEF = 32;
  localparam int STEP_CNT_W = $clog2(DRAW_W);

  localparam int SHIFT_A = 7;
  localparam int SHIFT_B = 9;
  localparam int SHIFT_C = 8;

  localparam logic [QTY_W-1:0] QTY_MOD = QTY_W'(100);

  // Quantity remainder: fold the 16-bit chunks of the draw, then divide the
  // folded sum by 100 through a reciprocal multiply.
  localparam int FOLD_W   = 24;
  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 31;
  localparam int QUO_W    = FOLD_W + RECIP_W - RECIP_SH;
  localparam logic [FOLD_W-1:0]  QTY_POW16_MOD = FOLD_W'(36);        // 2^16 mod 100
  localparam logic [FOLD_W-1:0]  QTY_POW32_MOD = FOLD_W'(96);        // 2^32 mod 100
  localparam logic [FOLD_W-1:0]  QTY_POW48_MOD = FOLD_W'(56);        // 2^48 mod 100
  localparam logic [RECIP_W-1:0] QTY_RECIP     = RECIP_W'(21474837);  // ceil(2^31 / 100)

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;

  // Register indexes, taken from paddr[4:3]
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd2;

  localparam logic [DRAW_W-1:0]   SEED_RST   = '0;
  localparam logic [BAND_W-1:0]   BAND_RST   = BAND_W'(1);
  localparam logic [CENTER_W-1:0] CENTER_RST = '0;
  localparam logic [DRAW_W-1:0]   GEN_RST    = DRAW_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_RUN,
    S_FIN
  } rog_state_t;

  typedef struct packed {
    logic load;    // take a request, apply restart, first draw into divider
    logic draw;    // second and third draws
    logic step;    // one bit of the price remainder, one stage of the quantity remainder
    logic finish;  // form price and quantity, fill output register
  } rog_cmd_t;

  typedef struct packed {
    logic last_step;
  } rog_sts_t;

  function automatic logic [DRAW_W-1:0] xs_step(input logic [DRAW_W-1:0] x);
    logic [DRAW_W-1:0] a;
    logic [DRAW_W-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

`default_nettype wire

>>> design/rog_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module rog_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rog_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [rog_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [rog_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic      [rog_pkg::DRAW_W-1:0]        seed,
  output logic      [rog_pkg::BAND_W-1:0]        band,
  output logic      [rog_pkg::CENTER_W-1:0]      center
);

  logic [rog_pkg::DRAW_W-1:0]   seed_r;
  logic [rog_pkg::BAND_W-1:0]   band_r;
  logic [rog_pkg::CENTER_W-1:0] center_r;
  logic [rog_pkg::CFG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign idx   = cfg_paddr[rog_pkg::CFG_ADDR_W-1:3];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= rog_pkg::SEED_RST;
      band_r   <= rog_pkg::BAND_RST;
      center_r <= rog_pkg::CENTER_RST;
    end else if (wr_en) begin
      case (idx)
        rog_pkg::REG_SEED:   seed_r   <= cfg_pwdata;
        rog_pkg::REG_BAND:   band_r   <= cfg_pwdata[rog_pkg::BAND_W-1:0];
        rog_pkg::REG_CENTER: center_r <= cfg_pwdata[rog_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rog_pkg::REG_SEED:   cfg_prdata = seed_r;
      rog_pkg::REG_BAND:   cfg_prdata = rog_pkg::CFG_DATA_W'(band_r);
      rog_pkg::REG_CENTER: cfg_prdata = rog_pkg::CFG_DATA_W'(center_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign seed   = seed_r;
  assign band   = band_r;
  assign center = center_r;

endmodule

`default_nettype wire

>>> design/rog_ctrl.sv
// Controller state machine: sequences draws, remainder steps and output fill.
`default_nettype none

module rog_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output rog_pkg::rog_cmd_t      cmd,
  input  wire rog_pkg::rog_sts_t sts
);

  rog_pkg::rog_state_t state_r;
  rog_pkg::rog_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rog_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      rog_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = rog_pkg::S_DRAW;
        end
      end
      rog_pkg::S_DRAW: begin
        cmd.draw  = 1'b1;
        state_nxt = rog_pkg::S_RUN;
      end
      rog_pkg::S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = rog_pkg::S_FIN;
        end
      end
      rog_pkg::S_FIN: begin
        // hold the finished result until the output register frees up
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = rog_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rog_pkg::S_IDLE;
      end
    endcase

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while one is in flight");

  a_fill_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("output register filled but not shown");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rog_pkg::S_RUN && sts.last_step) |=> state_r == rog_pkg::S_FIN)
    else $error("remainder pass did not end in finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.finish)
    else $error("waiting result overwritten");

endmodule

`default_nettype wire

>>> design/rog_dp.sv
// Datapath: xorshift generator, order counter, remainder units, output register.
`default_nettype none

module rog_dp #(
  parameter int ID_BITS = rog_pkg::ID_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rog_pkg::rog_cmd_t                 cmd,
  output rog_pkg::rog_sts_t                      sts,
  input  wire logic                              restart,
  input  wire logic                              final_request,
  input  wire logic [rog_pkg::DRAW_W-1:0]        seed,
  input  wire logic [rog_pkg::BAND_W-1:0]        band,
  input  wire logic [rog_pkg::CENTER_W-1:0]      center,
  output logic      [rog_pkg::OUT_TDATA_W-1:0]   res_data,
  output logic                                   res_last
);

  localparam int DW = rog_pkg::DRAW_W;
  localparam int MW = rog_pkg::MOD_W;
  localparam int QW = rog_pkg::QTY_W;
  localparam int FW = rog_pkg::FOLD_W;
  localparam int PW = rog_pkg::FOLD_W + rog_pkg::RECIP_W;

  logic [DW-1:0]                     gen_r;
  logic [ID_BITS-1:0]                cnt_r;
  logic [DW-1:0]                     div_q_r;
  logic [MW-1:0]                     div_rem_r;
  logic [DW-1:0]                     qty_q_r;
  logic [FW-1:0]                     fold_r;
  logic [FW-1:0]                     fold_hold_r;
  logic [rog_pkg::QUO_W-1:0]         quo_r;
  logic [QW-1:0]                     r100_r;
  logic [rog_pkg::STEP_CNT_W-1:0]    step_cnt_r;
  logic                              side_r;
  logic                              last_r;

  logic [rog_pkg::ID_OUT_W-1:0]      id_out_r;
  logic                              sell_out_r;
  logic [rog_pkg::PRICE_W-1:0]       price_out_r;
  logic [QW-1:0]                     qty_out_r;
  logic                              last_out_r;

  logic [DW-1:0]                     gen_src;
  logic [DW-1:0]                     x1;
  logic [DW-1:0]                     x2;
  logic [DW-1:0]                     x3;
  logic [rog_pkg::BAND_W-1:0]        band_eff;
  logic [MW-1:0]                     modulus;
  logic [MW:0]                       rem_sh;
  logic [MW:0]                       rem_diff;
  logic [MW-1:0]                     rem_next;
  logic [FW-1:0]                     fold_sum;
  logic [PW-1:0]                     quo_prod;
  logic [rog_pkg::QUO_W-1:0]         quo_next;
  logic [FW-1:0]                     quo_x100;
  logic [rog_pkg::OFFSET_W-1:0]      offset;
  logic [rog_pkg::PRICE_W-1:0]       price;

  // zero seed and zero band both fall back to one
  assign gen_src  = !restart ? gen_r : ((seed == '0) ? DW'(1) : seed);
  assign x1       = rog_pkg::xs_step(gen_src);
  assign x2       = rog_pkg::xs_step(gen_r);
  assign x3       = rog_pkg::xs_step(x2);
  assign band_eff = (band == '0) ? rog_pkg::BAND_W'(1) : band;
  assign modulus  = {band_eff, 1'b1};

  // restoring remainder, one dividend bit a cycle
  assign rem_sh   = {div_rem_r, div_q_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, modulus};
  assign rem_next = (rem_sh >= {1'b0, modulus}) ? rem_diff[MW-1:0] : rem_sh[MW-1:0];

  // quantity remainder in three stages: fold the chunks by 2^(16k) mod 100,
  // take the quotient by reciprocal multiply, subtract
  assign fold_sum = FW'(qty_q_r[15:0])
                  + FW'(qty_q_r[31:16]) * rog_pkg::QTY_POW16_MOD
                  + FW'(qty_q_r[47:32]) * rog_pkg::QTY_POW32_MOD
                  + FW'(qty_q_r[63:48]) * rog_pkg::QTY_POW48_MOD;
  assign quo_prod = PW'(fold_r) * PW'(rog_pkg::QTY_RECIP);
  assign quo_next = quo_prod[PW-1:rog_pkg::RECIP_SH];
  assign quo_x100 = FW'(quo_r) * FW'(rog_pkg::QTY_MOD);

  assign offset = {1'b0, div_rem_r} - {2'b00, band_eff};
  assign price  = {center[rog_pkg::CENTER_W-1], center}
                + {{(rog_pkg::PRICE_W - rog_pkg::OFFSET_W){offset[rog_pkg::OFFSET_W-1]}},
                   offset};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r      <= rog_pkg::GEN_RST;
      cnt_r      <= '0;
      step_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        gen_r <= x1;
        cnt_r <= restart ? ID_BITS'(1) : cnt_r + ID_BITS'(1);
      end else if (cmd.draw) begin
        gen_r <= x3;
      end
      if (cmd.draw) begin
        step_cnt_r <= '0;
      end else if (cmd.step) begin
        step_cnt_r <= step_cnt_r + rog_pkg::STEP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_q_r   <= x1;
      div_rem_r <= '0;
      last_r    <= final_request;
    end else if (cmd.step) begin
      div_q_r   <= div_q_r << 1;
      div_rem_r <= rem_next;
    end
    if (cmd.draw) begin
      side_r      <= x2[0];
      qty_q_r     <= x3;
      fold_r      <= '0;
      fold_hold_r <= '0;
      quo_r       <= '0;
      r100_r      <= '0;
    end else if (cmd.step) begin
      fold_r      <= fold_sum;
      fold_hold_r <= fold_r;
      quo_r       <= quo_next;
      r100_r      <= QW'(fold_hold_r - quo_x100);
    end
    if (cmd.finish) begin
      id_out_r    <= rog_pkg::ID_OUT_W'(cnt_r);
      sell_out_r  <= side_r;
      price_out_r <= price;
      qty_out_r   <= r100_r + QW'(1);
      last_out_r  <= last_r;
    end
  end

  assign sts.last_step = (step_cnt_r == '1);
  assign res_data      = {qty_out_r, price_out_r, sell_out_r, id_out_r};
  assign res_last      = last_out_r;

  a_r100_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.draw) |=> (r100_r < rog_pkg::QTY_MOD))
    else $error("quantity remainder out of range");

  a_qty_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (qty_out_r != '0 && qty_out_r <= rog_pkg::QTY_MOD))
    else $error("quantity outside 1 to 100");

endmodule

`default_nettype wire

>>> design/random_order_generator.sv
// Top level of the random order generator: register file, controller and datapath.
//
// Usage:
//   Each request on the in_ stream yields one synthetic order on the out_ stream.
//   in_tdata[0] is restart: reload the 64-bit xorshift generator from seed_value
//   (zero seed loads one) and clear the order counter before this order.
//   in_tlast is final_request and comes back on out_tlast as last_order.
//   Each order steps the generator three times: the first draw modulo
//   2*band+1, minus band, plus center_price gives the price; bit 0 of the
//   second gives the side; the third draw modulo 100, plus one, gives quantity.
// Sequence:
//   The remainder units take one dividend bit a cycle. A request passes
//   through an accept step, a draw step, the remainder steps and a finish
//   step, and the block takes no new request until the last one is through.
//   The 64-bit restoring remainder pass sets the length of a request; the
//   modulo-100 unit runs alongside it.
// Reset and stall:
//   Synchronous reset loads state one into the generator, clears the counter
//   and loads the register reset values. A stalled receiver keeps the result
//   in the output register; a new request is still taken and worked on, and
//   its result waits in the finish step until the output register frees up.
`default_nettype none

module random_order_generator #(
  parameter int ID_BITS = rog_pkg::ID_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [rog_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic                              in_tlast,
  // out_tdata: [31:0] order_id, [32] is_sell, [80:33] price, [87:81] quantity
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [rog_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tlast,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [rog_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [rog_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [rog_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                   cfg_pready
);

  rog_pkg::rog_cmd_t                cmd;
  rog_pkg::rog_sts_t                sts;
  logic [rog_pkg::DRAW_W-1:0]       seed;
  logic [rog_pkg::BAND_W-1:0]       band;
  logic [rog_pkg::CENTER_W-1:0]     center;

  // no wait states on the configuration port
  assign cfg_pready = 1'b1;

  rog_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .seed        (seed),
    .band        (band),
    .center      (center)
  );

  // sequence one request at a time through the datapath
  rog_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rog_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .restart       (in_tdata[0]),
    .final_request (in_tlast),
    .seed          (seed),
    .band          (band),
    .center        (center),
    .res_data      (out_tdata),
    .res_last      (out_tlast)
  );

endmodule

`default_nettype wire

>>> tb/tb_random_order_generator.sv
// Testbench for the random order generator: predicted orders compared field by field.
`timescale 1ns / 1ps

module tb_random_order_generator;
  import rog_pkg::*;

  localparam int LIMIT_CYCLES = 400000;  // well past the slowest correct run
  localparam int HOLD_CYCLES  = 500;     // long receiver hold-off, forces input stall
  localparam int DRAIN_CYCLES = 80;      // a bit longer than one request takes through the block

  // One predicted order as it leaves the block.
  typedef struct {
    logic [ID_OUT_W-1:0] order_id;
    logic                is_sell;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    quantity;
    logic                last_order;
  } order_t;

  // Order predictor with its own copy of the registers and generator state.
  class order_scoreboard;
    logic [DRAW_W-1:0]   seed_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [CENTER_W-1:0] center_reg;
    logic [DRAW_W-1:0]   gen_state;
    logic [ID_OUT_W-1:0] order_count;
    order_t              pending_orders[$];
    int                  errors;

    function new();
      seed_reg    = '0;
      band_reg    = BAND_W'(1);
      center_reg  = '0;
      gen_state   = DRAW_W'(1);
      order_count = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SEED:   seed_reg   = value;
        REG_BAND:   band_reg   = value[BAND_W-1:0];
        REG_CENTER: center_reg = value[CENTER_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DRAW_W-1:0] advance();
      logic [DRAW_W-1:0] x;
      x = gen_state;
      x = x ^ (x << SHIFT_A);
      x = x ^ (x >> SHIFT_B);
      x = x ^ (x << SHIFT_C);
      gen_state = x;
      return x;
    endfunction

    // Work out the order that an accepted request will produce.
    function void note_request(logic restart, logic final_req);
      logic [63:0] eff_band;
      logic [63:0] modulus;
      logic [63:0] rem;
      logic [63:0] side_draw;
      logic [63:0] qty_draw;
      logic [63:0] offset;
      logic [63:0] center64;
      logic [63:0] sum;
      order_t      o;
      if (restart) begin
        gen_state   = (seed_reg == '0) ? DRAW_W'(1) : seed_reg;
        order_count = '0;
      end
      eff_band  = (band_reg == '0) ? 64'd1 : 64'(band_reg);
      modulus   = 64'd2 * eff_band + 64'd1;
      rem       = advance() % modulus;
      side_draw = advance();
      qty_draw  = advance();
      offset    = rem - eff_band;
      center64  = {{(64 - CENTER_W){center_reg[CENTER_W-1]}}, center_reg};
      sum       = center64 + offset;
      order_count = order_count + 1'b1;
      o.order_id   = order_count;
      o.is_sell    = side_draw[0];
      o.price      = sum[PRICE_W-1:0];
      o.quantity   = QTY_W'((qty_draw % 64'd100) + 64'd1);
      o.last_order = final_req;
      pending_orders.insert(pending_orders.size(), o);
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    task check_order(input logic [OUT_TDATA_W-1:0] data, input logic last);
      order_t want;
      if (pending_orders.size() == 0) begin
        report_mismatch("order with no request pending", data[63:0], '0);
        return;
      end
      want = pending_orders.pop_front();
      if (data[31:0] !== want.order_id)
        report_mismatch("order_id", data[31:0], want.order_id);
      if (data[32] !== want.is_sell)
        report_mismatch("is_sell", data[32], want.is_sell);
      if (data[80:33] !== want.price)
        report_mismatch("price", data[80:33], want.price);
      if (data[87:81] !== want.quantity)
        report_mismatch("quantity", data[87:81], want.quantity);
      if (last !== want.last_order)
        report_mismatch("last_order", last, want.last_order);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [0] restart, [7:1] zero
  logic                  in_tlast = 1'b0; // final_request

  // order side
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] order_id, [32] is_sell, [80:33] price,
                                      // [87:81] quantity
  logic                   out_tlast;  // last_order

  // register port
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  order_scoreboard board;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;     // raised once by the stimulus
  bit hold_done = 1'b0;   // owned by the receiver process
  int hold_count = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  random_order_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Guard against a hung block: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: check each taken order, then pick the next ready value.
  // Values sampled here are the ones from before this edge, so the
  // handshake seen matches the one the block saw.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_order(out_tdata, out_tlast);
    if (hold_go && !hold_done) begin
      // hold off for a long stretch so the block backs up into its input
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES)
        hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, value);
    // drop the select and let the bus go idle so the next write starts cleanly
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setup(input logic [63:0] seed, input logic [63:0] band,
                             input logic [63:0] center);
    write_register(REG_SEED, seed);
    write_register(REG_BAND, band);
    write_register(REG_CENTER, center);
  endtask

  // Offer one request and hold it until taken; then maybe idle for a while.
  // Gaps are mostly short, sometimes long enough to land anywhere in the
  // block's handling of a request.
  task automatic send_request(input logic restart, input logic final_req);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 1){1'b0}}, restart};
    in_tlast  <= final_req;
    do @(posedge clk); while (!in_tready);
    board.note_request(restart, final_req);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 90) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted order has come out.
  task automatic drain_orders();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_orders.size() != 0) @(posedge clk);
  endtask

  task automatic load_random_setup();
    logic [63:0] seed;
    logic [63:0] band;
    logic [63:0] center;
    case ($urandom_range(0, 3))
      0:       seed = '0;
      1:       seed = '1;
      default: seed = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0:       band = 64'd0;
      1:       band = 64'h7FFF_FFFF;
      2:       band = 64'd1;
      3:       band = 64'($urandom_range(2, 50));
      4:       band = 64'($urandom_range(51, 100000));
      default: band = 64'($urandom & 32'h7FFF_FFFF);
    endcase
    case ($urandom_range(0, 4))
      0:       center = 64'hFFFF_C000_0000_0000;  // most negative center
      1:       center = 64'h0000_3FFF_FFFF_FFFF;  // most positive center
      2:       center = 64'($urandom_range(0, 2000));
      default: begin
        center = {$urandom, $urandom};
        center = {{17{center[46]}}, center[46:0]};
      end
    endcase
    write_setup(seed, band, center);
  endtask

  initial begin
    int mode;
    int sent;
    int chunk;
    int len;
    int k;
    logic rs;
    logic fin;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: after reset, no restart, generator runs from state one.
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    drain_orders();

    // Zero seed loads one, zero band acts as one, most negative center.
    write_setup(64'd0, 64'd0, 64'hFFFF_C000_0000_0000);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    drain_orders();

    // All-ones seed, widest band, most positive center; restart three times.
    write_setup('1, 64'h7FFF_FFFF, 64'h0000_3FFF_FFFF_FFFF);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    drain_orders();

    // Narrowest real band, center at zero, single-bit seed.
    write_setup(64'h8000_0000_0000_0000, 64'd1, 64'd0);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b0, 1'b1);
    drain_orders();

    // Random: three idling modes, each in chunks with a fresh setup.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 16; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < 184) begin
        drain_orders();
        load_random_setup();
        // the long hold-off starts with the first random chunk
        if (mode == 0) hold_go = 1'b1;
        chunk = 0;
        while (chunk < 46) begin
          // a batch: restart usually at the head, final flag usually on the tail
          len = $urandom_range(1, 16);
          if (len > 46 - chunk) len = 46 - chunk;
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              rs  = $urandom_range(0, 1);
              fin = $urandom_range(0, 1);
            end else begin
              rs  = (k == 0) && ($urandom_range(0, 4) != 0);
              fin = (k == len - 1);
            end
            send_request(rs, fin);
          end
          chunk += len;
        end
        sent += chunk;
      end
    end

    drain_orders();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_orders.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
